FILE: rtl/core/sst_pkg.sv
// shared constants and types for the static search table
package sst_pkg;
   localparam int Depth     = 64;
   localparam int KeyWidth  = 32;
   localparam int DataWidth = 32;
   localparam int AddrWidth = $clog2(Depth);
   localparam int CntWidth  = $clog2(Depth + 1);

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic MODE_SEQ    = 1'b0;
   localparam logic MODE_SORTED = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SEQ    = 9'b000000010,
      ST_BIN    = 9'b000000100,
      ST_SORT_I = 9'b000001000,
      ST_SORT_J = 9'b000010000,
      ST_SWAP_A = 9'b000100000,
      ST_SWAP_B = 9'b001000000,
      ST_DATA   = 9'b010000000,
      ST_CMP    = 9'b100000000
   } state_type;
endpackage

FILE: rtl/core/static_search_table.sv
// static search table: record store with sequential scan, binary search and sort on close
// load writes one record; sequential lookup reads then compares each entry from the back
// binary lookup reads then compares each probe; a sorted close adds a selection sort
// throughput: one item at a time, busy stays high while a lookup walks or the sort runs
// the receiver cannot stall: a result shows on rsp_ ports for one cycle with rsp_valid
// reset clears count, closed flag, mode and control; memories are not cleared
module static_search_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [sst_pkg::KeyWidth-1:0]  req_search_key,
   input  logic [sst_pkg::DataWidth-1:0] req_record_data,
   input  logic                          req_last_record,
   input  logic                          csr_write,
   input  logic                          csr_search_mode,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [6:0]                    rsp_position,
   output logic [31:0]                   rsp_match_data,
   output logic [6:0]                    rsp_entry_total
);
   localparam int AW = sst_pkg::AddrWidth;
   localparam int CW = sst_pkg::CntWidth;

   // key and payload memories, registered read
   logic [sst_pkg::KeyWidth-1:0]  key_mem  [sst_pkg::Depth];
   logic [sst_pkg::DataWidth-1:0] data_mem [sst_pkg::Depth];
   logic [sst_pkg::KeyWidth-1:0]  key_rd_ff;
   logic [sst_pkg::DataWidth-1:0] data_rd_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [sst_pkg::KeyWidth-1:0]  wr_key;
   logic [sst_pkg::DataWidth-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= wr_key;
         data_mem[wr_addr] <= wr_data;
      end
      key_rd_ff  <= key_mem[rd_addr];
      data_rd_ff <= data_mem[rd_addr];
   end

   sst_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          closed_ff, closed_in;
   logic          mode_ff;
   logic [sst_pkg::KeyWidth-1:0]  key_ff, key_in;   // searched key / held key during swap
   logic [sst_pkg::DataWidth-1:0] hold_ff, hold_in; // payload held during swap
   logic [CW:0]   low_ff, low_in, high_ff, high_in; // signed-free bounds, one extra bit
   logic [CW-1:0] ptr_ff, ptr_in;                   // scan pointer / sort j
   logic [CW-1:0] outer_ff, outer_in;               // sort i
   logic [CW-1:0] min_ff, min_in;
   logic [sst_pkg::KeyWidth-1:0] min_key_ff, min_key_in;
   logic [sst_pkg::DataWidth-1:0] min_data_ff, min_data_in;
   logic          rv_ff, rv_in, rf_ff, rf_in;
   logic [CW-1:0] rp_ff, rp_in;
   logic [sst_pkg::DataWidth-1:0] rd_out_ff, rd_out_in;
   logic [CW:0]   mid;

   assign mid  = (low_ff + high_ff) >> 1;
   assign busy = (state_ff != sst_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sst_pkg::ST_IDLE;
         count_ff  <= '0;
         closed_ff <= 1'b0;
         mode_ff   <= sst_pkg::MODE_SEQ;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         closed_ff <= closed_in;
         rv_ff     <= rv_in;
         if (csr_write) mode_ff <= csr_search_mode;
      end
      key_ff      <= key_in;
      hold_ff     <= hold_in;
      low_ff      <= low_in;
      high_ff     <= high_in;
      ptr_ff      <= ptr_in;
      outer_ff    <= outer_in;
      min_ff      <= min_in;
      min_key_ff  <= min_key_in;
      min_data_ff <= min_data_in;
      rf_ff       <= rf_in;
      rp_ff       <= rp_in;
      rd_out_ff   <= rd_out_in;
   end

   always_comb begin
      state_in = state_ff; count_in = count_ff; closed_in = closed_ff;
      key_in = key_ff; hold_in = hold_ff; low_in = low_ff; high_in = high_ff;
      ptr_in = ptr_ff; outer_in = outer_ff; min_in = min_ff;
      min_key_in = min_key_ff; min_data_in = min_data_ff;
      rv_in = 1'b0; rf_in = rf_ff; rp_in = rp_ff; rd_out_in = rd_out_ff;
      rd_addr = ptr_ff[AW-1:0];
      wr_en = 1'b0; wr_addr = '0; wr_key = req_search_key; wr_data = req_record_data;
      case (state_ff)
         sst_pkg::ST_IDLE: begin
            if (start) begin
               key_in = req_search_key;
               if (req_operation == sst_pkg::OP_LOAD) begin
                  logic [CW-1:0] base;
                  base = closed_ff ? '0 : count_ff;
                  closed_in = req_last_record;
                  count_in  = base;
                  if (base < CW'(sst_pkg::Depth)) begin
                     wr_en    = 1'b1;
                     wr_addr  = base[AW-1:0];
                     count_in = base + 1'b1;
                  end
                  if (req_last_record && mode_ff == sst_pkg::MODE_SORTED
                      && count_in > CW'(1)) begin
                     outer_in = '0;
                     state_in = sst_pkg::ST_SORT_I;
                  end
               end else if (mode_ff == sst_pkg::MODE_SEQ) begin
                  // scan from the back
                  if (count_ff == '0) begin
                     rv_in = 1'b1; rf_in = 1'b0; rp_in = '0; rd_out_in = '0;
                  end else begin
                     ptr_in   = count_ff - 1'b1;
                     state_in = sst_pkg::ST_SEQ;
                  end
               end else begin
                  low_in  = (CW+1)'(1);
                  high_in = {1'b0, count_ff};
                  state_in = sst_pkg::ST_BIN;
               end
            end
         end
         sst_pkg::ST_SEQ: begin
            // read of ptr issued; compare next cycle
            state_in = sst_pkg::ST_CMP;
            low_in   = '0;
         end
         sst_pkg::ST_BIN: begin
            if (low_ff > high_ff) begin
               rv_in = 1'b1; rf_in = 1'b0; rp_in = '0; rd_out_in = '0;
               state_in = sst_pkg::ST_IDLE;
            end else begin
               rd_addr  = AW'(mid - 1'b1);
               ptr_in   = CW'(mid);
               low_in   = low_ff;
               state_in = sst_pkg::ST_CMP;
            end
         end
         sst_pkg::ST_CMP: begin
            if (mode_ff == sst_pkg::MODE_SEQ) begin
               // sequential compare of entry ptr
               if (key_rd_ff == key_ff) begin
                  rv_in = 1'b1; rf_in = 1'b1; rp_in = ptr_ff + 1'b1;
                  rd_out_in = data_rd_ff; state_in = sst_pkg::ST_IDLE;
               end else if (ptr_ff == '0) begin
                  rv_in = 1'b1; rf_in = 1'b0; rp_in = '0; rd_out_in = '0;
                  state_in = sst_pkg::ST_IDLE;
               end else begin
                  ptr_in = ptr_ff - 1'b1; state_in = sst_pkg::ST_SEQ;
               end
            end else begin
               if (key_ff == key_rd_ff) begin
                  rv_in = 1'b1; rf_in = 1'b1; rp_in = ptr_ff;
                  rd_out_in = data_rd_ff; state_in = sst_pkg::ST_IDLE;
               end else begin
                  if (key_ff < key_rd_ff) high_in = {1'b0, ptr_ff} - 1'b1;
                  else                    low_in  = {1'b0, ptr_ff} + 1'b1;
                  state_in = sst_pkg::ST_BIN;
               end
            end
         end
         sst_pkg::ST_SORT_I: begin
            // read entry i as initial minimum
            rd_addr  = outer_ff[AW-1:0];
            min_in   = outer_ff;
            ptr_in   = outer_ff;
            state_in = sst_pkg::ST_DATA;
         end
         sst_pkg::ST_DATA: begin
            // capture entry i, issue read of i+1
            min_key_in  = key_rd_ff;
            min_data_in = data_rd_ff;
            key_in      = key_rd_ff;
            hold_in     = data_rd_ff;
            ptr_in      = ptr_ff + 1'b1;
            rd_addr     = AW'(ptr_ff + 1'b1);
            state_in    = sst_pkg::ST_SORT_J;
         end
         sst_pkg::ST_SORT_J: begin
            // key_rd_ff holds entry ptr
            if (key_rd_ff < min_key_ff) begin
               min_in = ptr_ff; min_key_in = key_rd_ff; min_data_in = data_rd_ff;
            end
            if (ptr_ff + 1'b1 < count_ff) begin
               ptr_in  = ptr_ff + 1'b1;
               rd_addr = AW'(ptr_ff + 1'b1);
            end else begin
               state_in = sst_pkg::ST_SWAP_A;
            end
         end
         sst_pkg::ST_SWAP_A: begin
            // minimum into place i
            wr_en   = 1'b1;
            wr_addr = outer_ff[AW-1:0];
            wr_key  = min_key_ff;
            wr_data = min_data_ff;
            state_in = sst_pkg::ST_SWAP_B;
         end
         sst_pkg::ST_SWAP_B: begin
            // old entry i into the minimum's place
            wr_en   = (min_ff != outer_ff);
            wr_addr = min_ff[AW-1:0];
            wr_key  = key_ff;
            wr_data = hold_ff;
            outer_in = outer_ff + 1'b1;
            min_in   = '0;
            if (outer_ff + 2'd2 < {1'b0, count_ff}) state_in = sst_pkg::ST_SORT_I;
            else                                    state_in = sst_pkg::ST_IDLE;
         end
         default: state_in = sst_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid       = rv_ff;
   assign rsp_found       = rf_ff;
   assign rsp_position    = 7'(rp_ff);
   assign rsp_match_data  = rd_out_ff;
   assign rsp_entry_total = 7'(count_ff);
endmodule

FILE: test/static_search_table_test.sv
// self-checking testbench for the static search table
module static_search_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 200000;

   // one request beat as the driver presents it
   typedef struct packed {
      logic                          op;
      logic [sst_pkg::KeyWidth-1:0]  key;
      logic [sst_pkg::DataWidth-1:0] data;
      logic                          last;
   } table_req_type;

   // one lookup answer
   typedef struct packed {
      logic                          found;
      logic [6:0]                    position;
      logic [sst_pkg::DataWidth-1:0] match_data;
      logic [6:0]                    total;
   } lookup_answer_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_operation = sst_pkg::OP_LOAD;
   logic [sst_pkg::KeyWidth-1:0]  req_search_key = '0;
   logic [sst_pkg::DataWidth-1:0] req_record_data = '0;
   logic                          req_last_record = 1'b0;
   logic                          csr_write = 1'b0;
   logic                          csr_search_mode = sst_pkg::MODE_SEQ;
   logic                          rsp_valid;
   logic                          rsp_found;
   logic [6:0]                    rsp_position;
   logic [31:0]                   rsp_match_data;
   logic [6:0]                    rsp_entry_total;

   // pending request beats and answers still owed by the block
   table_req_type     pending_reqs[$];
   lookup_answer_type owed_answers[$];

   // shadow copy of the table
   logic [sst_pkg::KeyWidth-1:0]  shadow_keys[sst_pkg::Depth];
   logic [sst_pkg::DataWidth-1:0] shadow_data[sst_pkg::Depth];
   int                            shadow_count = 0;
   bit                            shadow_closed = 1'b0;
   logic                          shadow_mode = sst_pkg::MODE_SEQ;

   bit gaps_on = 1'b1;      // random sender gaps
   int mismatches = 0;
   int issued = 0;
   int stall_cycles = 0;

   always #5 clock = ~clock;

   static_search_table dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_search_key (req_search_key),
      .req_record_data(req_record_data),
      .req_last_record(req_last_record),
      .csr_write      (csr_write),
      .csr_search_mode(csr_search_mode),
      .rsp_valid      (rsp_valid),
      .rsp_found      (rsp_found),
      .rsp_position   (rsp_position),
      .rsp_match_data (rsp_match_data),
      .rsp_entry_total(rsp_entry_total)
   );

   // ascending selection sort, minimum swapped into place
   task automatic sort_shadow();
      int                            m;
      logic [sst_pkg::KeyWidth-1:0]  tk;
      logic [sst_pkg::DataWidth-1:0] td;
      for (int i = 0; i + 1 < shadow_count; i++) begin
         m = i;
         for (int j = i + 1; j < shadow_count; j++)
            if (shadow_keys[j] < shadow_keys[m]) m = j;
         if (m != i) begin
            tk = shadow_keys[i];
            td = shadow_data[i];
            shadow_keys[i] = shadow_keys[m];
            shadow_data[i] = shadow_data[m];
            shadow_keys[m] = tk;
            shadow_data[m] = td;
         end
      end
   endtask

   // back-to-front scan, highest matching position wins
   function automatic int scan_position(logic [sst_pkg::KeyWidth-1:0] key);
      for (int p = shadow_count; p > 0; p--)
         if (shadow_keys[p-1] == key) return p;
      return 0;
   endfunction

   // binary search with midpoint (low+high)/2 on the table as stored
   function automatic int bisect_position(logic [sst_pkg::KeyWidth-1:0] key);
      int low;
      int high;
      int mid;
      low = 1;
      high = shadow_count;
      while (low <= high) begin
         mid = (low + high) / 2;
         if (key == shadow_keys[mid-1]) return mid;
         if (key < shadow_keys[mid-1]) high = mid - 1;
         else low = mid + 1;
      end
      return 0;
   endfunction

   // update the shadow table for one accepted beat, queue the answer for lookups
   task automatic apply_beat(table_req_type r);
      int                pos;
      lookup_answer_type a;
      if (r.op == sst_pkg::OP_LOAD) begin
         // a load after close starts a fresh table
         if (shadow_closed) begin
            shadow_count = 0;
            shadow_closed = 1'b0;
         end
         // loads into a full table are dropped
         if (shadow_count < sst_pkg::Depth) begin
            shadow_keys[shadow_count] = r.key;
            shadow_data[shadow_count] = r.data;
            shadow_count++;
         end
         // the last mark closes even when the record was dropped
         if (r.last) begin
            shadow_closed = 1'b1;
            if (shadow_mode == sst_pkg::MODE_SORTED) sort_shadow();
         end
      end else begin
         pos = (shadow_mode == sst_pkg::MODE_SORTED) ? bisect_position(r.key)
                                                     : scan_position(r.key);
         a.found = (pos != 0);
         a.position = pos[6:0];
         a.match_data = (pos != 0) ? shadow_data[pos-1] : '0;
         a.total = shadow_count[6:0];
         owed_answers.push_back(a);
      end
   endtask

   // driver: presents pending beats, predicts each one as it is accepted
   always @(posedge clock) begin : driver
      table_req_type cur;
      table_req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            cur.op = req_operation;
            cur.key = req_search_key;
            cur.data = req_record_data;
            cur.last = req_last_record;
            apply_beat(cur);
         end
         // a held beat stays up while busy; otherwise load the next one or gap
         if (!start || !busy) begin
            if (pending_reqs.size() > 0 && !(gaps_on && $urandom_range(99) < 18)) begin
               nxt = pending_reqs.pop_front();
               start <= 1'b1;
               req_operation <= nxt.op;
               req_search_key <= nxt.key;
               req_record_data <= nxt.data;
               req_last_record <= nxt.last;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every answer beat is checked against the oldest owed answer
   always @(posedge clock) begin : monitor
      lookup_answer_type want;
      if (!reset && rsp_valid) begin
         if (owed_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected answer: found=%0b pos=%0d data=%h total=%0d",
                        rsp_found, rsp_position, rsp_match_data, rsp_entry_total);
         end else begin
            want = owed_answers.pop_front();
            if (rsp_found !== want.found || rsp_position !== want.position ||
                rsp_match_data !== want.match_data || rsp_entry_total !== want.total) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"answer mismatch: exp found=%0b pos=%0d data=%h total=%0d,",
                            " got found=%0b pos=%0d data=%h total=%0d"},
                           want.found, want.position, want.match_data, want.total,
                           rsp_found, rsp_position, rsp_match_data, rsp_entry_total);
            end
         end
      end
   end

   // watchdog: too long without any beat moving ends the run
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == WatchdogLimit) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic push_req(logic op, logic [sst_pkg::KeyWidth-1:0] key,
                           logic [sst_pkg::DataWidth-1:0] data, logic last);
      table_req_type r;
      r.op = op;
      r.key = key;
      r.data = data;
      r.last = last;
      pending_reqs.push_back(r);
      issued++;
   endtask

   // wait for all beats to go in and all answers to come out, then for the
   // block to drop busy (a load may still be sorting)
   task automatic wait_quiet();
      while (pending_reqs.size() > 0 || start || owed_answers.size() > 0) @(posedge clock);
      repeat (3) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // mode register write, only called once the block is quiet
   task automatic write_mode(logic m);
      csr_write <= 1'b1;
      csr_search_mode <= m;
      shadow_mode = m;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [sst_pkg::KeyWidth-1:0] pick_key(int flavor);
      case (flavor)
         0: return sst_pkg::KeyWidth'($urandom_range(15));
         1: return sst_pkg::KeyWidth'($urandom);
         default: begin
            case ($urandom_range(3))
               0: return '0;
               1: return '1;
               2: return sst_pkg::KeyWidth'($urandom_range(3));
               default: return '1 - sst_pkg::KeyWidth'($urandom_range(3));
            endcase
         end
      endcase
   endfunction

   // one random table: optional early lookups, a fill that may overrun the depth, usually closed, then lookups
   task automatic random_phase();
      int                           n;
      int                           flavor;
      int                           lookups;
      logic [sst_pkg::KeyWidth-1:0] loaded[$];
      logic [sst_pkg::KeyWidth-1:0] k;
      n = ($urandom_range(15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
      flavor = $urandom_range(2);
      // now and then a few lookups on whatever table is standing
      if ($urandom_range(5) == 0)
         repeat ($urandom_range(1, 3))
            push_req(sst_pkg::OP_LOOKUP, pick_key(flavor),
                     sst_pkg::DataWidth'($urandom), 1'($urandom));
      for (int i = 0; i < n; i++) begin
         k = pick_key(flavor);
         loaded.push_back(k);
         push_req(sst_pkg::OP_LOAD, k, sst_pkg::DataWidth'($urandom),
                  (i == n - 1) && ($urandom_range(7) != 0));
      end
      lookups = $urandom_range(2, 10);
      for (int i = 0; i < lookups; i++) begin
         k = ($urandom_range(2) != 0) ? loaded[$urandom_range(loaded.size() - 1)]
                                      : pick_key(flavor);
         push_req(sst_pkg::OP_LOOKUP, k, sst_pkg::DataWidth'($urandom), 1'($urandom));
      end
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sequential mode: empty table, extremes, duplicates, open-table lookup
      push_req(sst_pkg::OP_LOOKUP, '0, '0, 1'b0);
      push_req(sst_pkg::OP_LOAD, '0, '1, 1'b0);
      push_req(sst_pkg::OP_LOAD, '1, '0, 1'b0);
      push_req(sst_pkg::OP_LOAD, 32'd5, 32'h1111_1111, 1'b0);
      push_req(sst_pkg::OP_LOAD, 32'd5, 32'h2222_2222, 1'b0);
      push_req(sst_pkg::OP_LOOKUP, 32'd5, '0, 1'b1);          // last mark on a lookup is ignored
      push_req(sst_pkg::OP_LOOKUP, '1, '0, 1'b0);
      push_req(sst_pkg::OP_LOOKUP, 32'd7, '0, 1'b0);
      push_req(sst_pkg::OP_LOAD, 32'd9, 32'hA5A5_5A5A, 1'b1); // close
      push_req(sst_pkg::OP_LOOKUP, '0, '0, 1'b0);
      push_req(sst_pkg::OP_LOAD, 32'd3, 32'h0000_0003, 1'b0); // restarts the table
      push_req(sst_pkg::OP_LOAD, 32'd1, 32'h0000_0001, 1'b1);
      push_req(sst_pkg::OP_LOOKUP, 32'd9, '0, 1'b0);
      wait_quiet();

      // mode flip on a closed unsorted table: binary search over it as stored
      write_mode(sst_pkg::MODE_SORTED);
      push_req(sst_pkg::OP_LOOKUP, 32'd3, '0, 1'b0);
      push_req(sst_pkg::OP_LOOKUP, 32'd1, '0, 1'b0);
      // sorted close with duplicates and extremes
      push_req(sst_pkg::OP_LOAD, '1, 32'hDEAD_BEEF, 1'b0);
      push_req(sst_pkg::OP_LOAD, 32'd4, 32'h0000_0044, 1'b0);
      push_req(sst_pkg::OP_LOAD, '0, 32'h0000_0000, 1'b0);
      push_req(sst_pkg::OP_LOAD, 32'd4, 32'h0000_0045, 1'b1);
      push_req(sst_pkg::OP_LOOKUP, 32'd4, '0, 1'b0);
      push_req(sst_pkg::OP_LOOKUP, '1, '0, 1'b0);
      push_req(sst_pkg::OP_LOOKUP, '0, '0, 1'b0);
      push_req(sst_pkg::OP_LOOKUP, 32'd2, '0, 1'b0);
      wait_quiet();

      // overfill a sorted table: drops past the top, last mark on a dropped load
      for (int i = 0; i < sst_pkg::Depth + 3; i++)
         push_req(sst_pkg::OP_LOAD, sst_pkg::KeyWidth'($urandom),
                  sst_pkg::DataWidth'($urandom), i == sst_pkg::Depth + 2);
      push_req(sst_pkg::OP_LOOKUP, sst_pkg::KeyWidth'($urandom), '0, 1'b0);
      wait_quiet();
      write_mode(sst_pkg::MODE_SEQ);
      push_req(sst_pkg::OP_LOOKUP, '0, '0, 1'b0);
      wait_quiet();

      // random tables, mode possibly changed between them
      while (issued < 1900) begin
         gaps_on = !(issued > 700 && issued < 1000);   // one stretch without gaps
         if ($urandom_range(1)) write_mode(1'($urandom));
         random_phase();
         wait_quiet();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && owed_answers.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
